// ===== hdl/ssc_pkg.sv =====
// shared types, constants and decode functions for the seven-segment code scroller
package ssc_pkg;

    localparam int CODE_W  = 10;
    localparam int SEG_W   = 7;
    localparam int DIGIT_W = 4;
    localparam int REM_W   = 7;

    localparam logic [CODE_W-1:0]  CODE_MAX = 10'd999;
    localparam logic [DIGIT_W-1:0] GLYPH_E  = 4'hE;

    // reciprocal constants: x / 100 = (x * 41) >> 12 for x < 1000,
    // x / 10 = (x * 103) >> 10 for x < 100
    localparam int HUND_MUL   = 41;
    localparam int HUND_SHIFT = 12;
    localparam int TENS_MUL   = 103;
    localparam int TENS_SHIFT = 10;

    localparam int HUND_PROD_W = CODE_W + 6;
    localparam int TENS_PROD_W = REM_W + 7;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] hund;
        logic [REM_W-1:0]   rem;
    } hund_split_t;

    function automatic logic [SEG_W-1:0] hex_glyph(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] g;
        unique case (d)
            4'h0: g = 7'h77;
            4'h1: g = 7'h24;
            4'h2: g = 7'h5D;
            4'h3: g = 7'h6D;
            4'h4: g = 7'h2E;
            4'h5: g = 7'h6B;
            4'h6: g = 7'h7B;
            4'h7: g = 7'h25;
            4'h8: g = 7'h7F;
            4'h9: g = 7'h6F;
            4'hA: g = 7'h3F;
            4'hB: g = 7'h7A;
            4'hC: g = 7'h53;
            4'hD: g = 7'h7C;
            4'hE: g = 7'h5B;
            4'hF: g = 7'h1B;
            default: g = '0;
        endcase
        return g;
    endfunction

    // split a saturated code into hundreds digit and remainder below 100
    function automatic hund_split_t split_hund(input logic [CODE_W-1:0] code);
        logic [HUND_PROD_W-1:0] prod;
        logic [DIGIT_W-1:0]     h;
        logic [CODE_W-1:0]      r;
        hund_split_t            s;
        prod   = HUND_PROD_W'(code) * HUND_PROD_W'(HUND_MUL);
        h      = DIGIT_W'(prod >> HUND_SHIFT);
        r      = code - CODE_W'(h) * CODE_W'(100);
        s.hund = h;
        s.rem  = r[REM_W-1:0];
        return s;
    endfunction

    function automatic logic [DIGIT_W-1:0] tens_of(input logic [REM_W-1:0] rem);
        logic [TENS_PROD_W-1:0] prod;
        prod = TENS_PROD_W'(rem) * TENS_PROD_W'(TENS_MUL);
        return DIGIT_W'(prod >> TENS_SHIFT);
    endfunction

endpackage

// ===== hdl/ssc_cell.sv =====
// one character cell of the text ring: loads a glyph or takes its neighbor's
module ssc_cell
    import ssc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [SEG_W-1:0] load_glyph,
    input  logic [SEG_W-1:0] shift_in,
    output logic [SEG_W-1:0] glyph
);

    logic [SEG_W-1:0] glyph_reg;
    logic [SEG_W-1:0] glyph_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            glyph_next = load_glyph;
        end
        else if (ctrl.shift)
        begin
            glyph_next = shift_in;
        end
        else
        begin
            glyph_next = glyph_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_reg <= '0;
        end
        else
        begin
            glyph_reg <= glyph_next;
        end
    end

    assign glyph = glyph_reg;

endmodule

// ===== hdl/seven_segment_code_scroller.sv =====
// top level of the seven-segment error code scroller with its ring of text cells
//
// channel  dir  handshake                 payload
// s_*      in   s_tvalid / s_tready       tuser: cmd, tdata: error_code
// m_*      out  m_tvalid / m_tready       tdata: segments, showing
//
// one request per cycle while s_tready is high; each request gives a registered result
// the text ring rotates one cell per show tick, cell 0 is the current character
// load keeps hundreds digit and remainder; tens, units, glyphs are made on move to ring
// s_tready is low only while a result waits and m_tready is low
// reset clears the control state: nothing shown, nothing pending, blank phase first
module seven_segment_code_scroller
    import ssc_pkg::*;
#(
    parameter int TEXT_LENGTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] error_code, [15:10] zero
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [6:0] segments, [7] showing
);

    localparam int POS_W = $clog2(TEXT_LENGTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_LENGTH - 1);

    logic              accept;
    logic              tick;
    logic              load;
    logic              show;
    logic              xfer;

    logic [CODE_W-1:0] code_sat;
    hund_split_t       split_w;

    logic [DIGIT_W-1:0] pend_hund_reg;
    logic [DIGIT_W-1:0] pend_hund_next;
    logic [REM_W-1:0]   pend_rem_reg;
    logic [REM_W-1:0]   pend_rem_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic               shown_valid_reg;
    logic               shown_valid_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               phase_reg;
    logic               phase_next;
    logic [SEG_W-1:0]   seg_hold_reg;
    logic [SEG_W-1:0]   seg_hold_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_data_reg;
    logic [7:0]         out_data_next;

    logic [DIGIT_W-1:0] tens_d;
    logic [DIGIT_W-1:0] units_d;
    logic [SEG_W-1:0]   glyph_w [TEXT_LENGTH];
    cell_ctrl_t         cell_ctrl;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign tick     = accept && (cmd_t'(s_tuser) == CMD_TICK);
    assign load     = accept && (cmd_t'(s_tuser) == CMD_LOAD);
    assign show     = tick && phase_reg && shown_valid_reg;

    assign code_sat = (s_tdata[CODE_W-1:0] > CODE_MAX) ? CODE_MAX : s_tdata[CODE_W-1:0];
    assign split_w  = split_hund(code_sat);

    assign tens_d  = tens_of(pend_rem_reg);
    assign units_d = DIGIT_W'(pend_rem_reg - REM_W'(tens_d) * REM_W'(10));

    always_comb
    begin
        pos_next = pos_reg;
        if (show)
        begin
            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_W'(1);
        end
    end

    assign xfer = tick && (pos_next == '0) && pend_valid_reg;

    always_comb
    begin
        pend_hund_next   = pend_hund_reg;
        pend_rem_next    = pend_rem_reg;
        pend_valid_next  = pend_valid_reg;
        phase_next       = phase_reg;
        seg_hold_next    = seg_hold_reg;
        shown_valid_next = shown_valid_reg || xfer;
        if (load)
        begin
            pend_hund_next  = split_w.hund;
            pend_rem_next   = split_w.rem;
            pend_valid_next = 1'b1;
        end
        else if (xfer)
        begin
            pend_valid_next = 1'b0;
        end
        if (tick)
        begin
            phase_next = !phase_reg;
            if (!phase_reg)
            begin
                seg_hold_next = '0;
            end
            else if (show)
            begin
                seg_hold_next = glyph_w[0];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {shown_valid_next, seg_hold_next};
        end
    end

    assign cell_ctrl.load  = xfer;
    assign cell_ctrl.shift = show;

    // ring of character cells, each takes the glyph of the next position
    for (genvar i = 0; i < TEXT_LENGTH; i++)
    begin : g_cell
        logic [SEG_W-1:0] load_glyph;
        if (i == 0)
        begin : g_e
            assign load_glyph = hex_glyph(GLYPH_E);
        end
        else if (i == 1)
        begin : g_hund
            assign load_glyph = hex_glyph(pend_hund_reg);
        end
        else if (i == 2)
        begin : g_tens
            assign load_glyph = hex_glyph(tens_d);
        end
        else if (i == 3)
        begin : g_units
            assign load_glyph = hex_glyph(units_d);
        end
        else
        begin : g_blank
            assign load_glyph = '0;
        end

        ssc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .load_glyph (load_glyph),
            .shift_in   (glyph_w[(i + 1) % TEXT_LENGTH]),
            .glyph      (glyph_w[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg  <= 1'b0;
            shown_valid_reg <= 1'b0;
            pos_reg         <= '0;
            phase_reg       <= 1'b0;
            seg_hold_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pend_valid_reg  <= pend_valid_next;
            shown_valid_reg <= shown_valid_next;
            pos_reg         <= pos_next;
            phase_reg       <= phase_next;
            seg_hold_reg    <= seg_hold_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_hund_reg <= pend_hund_next;
        pend_rem_reg  <= pend_rem_next;
        out_data_reg  <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // once a text is shown it stays shown
    a_shown_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        shown_valid_reg |=> shown_valid_reg)
        else $error("shown text was dropped");

    // the position only moves while a text is shown
    a_pos_needs_text: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != '0) |-> shown_valid_reg)
        else $error("position moved with no text");

    // a tick on the blank phase clears the segments
    a_blank_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && !phase_reg) |=> (seg_hold_reg == '0))
        else $error("blank phase left segments lit");

    // a pending code is taken over only at position zero
    a_xfer_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !pend_valid_next && !load) |=> (pos_reg == '0))
        else $error("pending code taken mid-text");
`endif

endmodule
